// ===== rtl/imp_pkg.sv =====
// Shared types, bus phase codes and the fixed poll script for the magnetometer poller.
package imp_pkg;

  // Bit-level bus phase, one-hot
  typedef enum logic [22:0] {
    PH_IDLE   = 23'h000001,
    PH_READY  = 23'h000002,
    PH_S1     = 23'h000004,
    PH_S2     = 23'h000008,
    PH_S3     = 23'h000010,
    PH_W1     = 23'h000020,
    PH_W2     = 23'h000040,
    PH_W3     = 23'h000080,
    PH_WA1    = 23'h000100,
    PH_WA2    = 23'h000200,
    PH_WA3    = 23'h000400,
    PH_ACKED  = 23'h000800,
    PH_NACKED = 23'h001000,
    PH_R1     = 23'h002000,
    PH_R2     = 23'h004000,
    PH_R3     = 23'h008000,
    PH_R4     = 23'h010000,
    PH_RA1    = 23'h020000,
    PH_RA2    = 23'h040000,
    PH_RDONE  = 23'h080000,
    PH_P1     = 23'h100000,
    PH_P2     = 23'h200000,
    PH_P3     = 23'h400000
  } phase_t;

  // Script opcodes
  typedef enum logic [3:0] {
    OP_START  = 4'd0,
    OP_WADDR  = 4'd1,
    OP_WRADDR = 4'd2,
    OP_WLIT   = 4'd3,
    OP_WA     = 4'd4,
    OP_WB     = 4'd5,
    OP_WMODE  = 4'd6,
    OP_READ   = 4'd7,
    OP_STOP   = 4'd8,
    OP_WAIT   = 4'd9,
    OP_LOOP   = 4'd10
  } op_t;

  // Configuration register indexes
  localparam logic [2:0] REG_WADDR = 3'd0;
  localparam logic [2:0] REG_SETA  = 3'd1;
  localparam logic [2:0] REG_SETB  = 3'd2;
  localparam logic [2:0] REG_MODE  = 3'd3;
  localparam logic [2:0] REG_WAIT  = 3'd4;

  // Reset values of the configuration registers
  localparam logic [7:0] WADDR_RST = 8'h3C;
  localparam logic [7:0] SETA_RST  = 8'h38;
  localparam logic [7:0] SETB_RST  = 8'h40;
  localparam logic [7:0] MODE_RST  = 8'h00;
  localparam logic [7:0] WAIT_RST  = 8'd100;

  // Reading that the sensor reports on overflow
  localparam logic [15:0] BAD_WORD = 16'hF000;

  typedef struct packed {
    op_t        op;
    logic [2:0] arg;
  } entry_t;

  // Bus state that both step stages update
  typedef struct packed {
    phase_t     phase;
    logic [2:0] bit_index;
    logic [7:0] tx_byte;
    logic [7:0] rx_byte;
    logic       scl;
    logic       sda;
  } bus_t;

  // Fixed poll script: setup writes, wait, pointer write, six-byte read, loop
  function automatic entry_t script_entry(input logic [4:0] pos);
    entry_t e;
    e.arg = 3'd0;
    unique case (pos)
      5'd0, 5'd5, 5'd10, 5'd16, 5'd20: e.op = OP_START;
      5'd1, 5'd6, 5'd11, 5'd17:        e.op = OP_WADDR;
      5'd2:  e.op = OP_WLIT;
      5'd7:  begin e.op = OP_WLIT; e.arg = 3'd1; end
      5'd12: begin e.op = OP_WLIT; e.arg = 3'd2; end
      5'd18: begin e.op = OP_WLIT; e.arg = 3'd3; end
      5'd3:  e.op = OP_WA;
      5'd8:  e.op = OP_WB;
      5'd13: e.op = OP_WMODE;
      5'd4, 5'd9, 5'd14, 5'd19, 5'd28: e.op = OP_STOP;
      5'd15: e.op = OP_WAIT;
      5'd21: e.op = OP_WRADDR;
      5'd22: begin e.op = OP_READ; e.arg = 3'd0; end
      5'd23: begin e.op = OP_READ; e.arg = 3'd1; end
      5'd24: begin e.op = OP_READ; e.arg = 3'd2; end
      5'd25: begin e.op = OP_READ; e.arg = 3'd3; end
      5'd26: begin e.op = OP_READ; e.arg = 3'd4; end
      5'd27: begin e.op = OP_READ; e.arg = 3'd5; end
      default: e.op = OP_LOOP;
    endcase
    return e;
  endfunction

endpackage

// ===== rtl/imp_bus_step.sv =====
// One phase of the bit-level bus machine: start, byte write, byte read, stop.
module imp_bus_step import imp_pkg::*; (
  input  bus_t cur,
  input  logic sda_in,
  output bus_t nxt
);

  always_comb begin
    nxt = cur;
    unique case (cur.phase)
      // start condition
      PH_S1: begin nxt.scl = 1'b1; nxt.sda = 1'b1; nxt.phase = PH_S2; end
      PH_S2: begin nxt.sda = 1'b0; nxt.phase = PH_S3; end
      PH_S3: begin nxt.scl = 1'b0; nxt.phase = PH_READY; end
      // write bits, MSB first
      PH_W1: begin nxt.sda = cur.tx_byte[cur.bit_index]; nxt.phase = PH_W2; end
      PH_W2: begin nxt.scl = 1'b1; nxt.phase = PH_W3; end
      PH_W3: begin
        nxt.scl = 1'b0;
        if (cur.bit_index == 3'd0) begin
          nxt.phase = PH_WA1;
        end else begin
          nxt.bit_index = cur.bit_index - 3'd1;
          nxt.phase     = PH_W1;
        end
      end
      // slave ACK slot
      PH_WA1: begin nxt.sda = 1'b1; nxt.phase = PH_WA2; end
      PH_WA2: begin nxt.scl = 1'b1; nxt.phase = PH_WA3; end
      PH_WA3: begin nxt.scl = 1'b0; nxt.phase = sda_in ? PH_NACKED : PH_ACKED; end
      // read bits, MSB first
      PH_R1: begin nxt.sda = 1'b1; nxt.phase = PH_R2; end
      PH_R2: begin nxt.scl = 1'b1; nxt.phase = PH_R3; end
      PH_R3: begin
        if (sda_in) nxt.rx_byte[cur.bit_index] = 1'b1;
        nxt.scl = 1'b0;
        if (cur.bit_index == 3'd0) begin
          nxt.phase = PH_R4;
        end else begin
          nxt.bit_index = cur.bit_index - 3'd1;
          nxt.phase     = PH_R2;
        end
      end
      // master ACK
      PH_R4:  begin nxt.sda = 1'b0; nxt.phase = PH_RA1; end
      PH_RA1: begin nxt.scl = 1'b1; nxt.phase = PH_RA2; end
      PH_RA2: begin nxt.scl = 1'b0; nxt.phase = PH_RDONE; end
      // stop condition
      PH_P1: begin nxt.sda = 1'b0; nxt.phase = PH_P2; end
      PH_P2: begin nxt.scl = 1'b1; nxt.phase = PH_P3; end
      PH_P3: begin nxt.sda = 1'b1; nxt.phase = PH_IDLE; end
      // idle, ready and byte-done phases wait for the script
      default: ;
    endcase
  end

endmodule

// ===== rtl/imp_script_step.sv =====
// One step of the poll script sequencer, after the bus phase has advanced.
module imp_script_step import imp_pkg::*; (
  input  bus_t             bus,
  input  logic [4:0]       pos,
  input  logic [7:0]       delay,
  input  logic [7:0]       waddr,
  input  logic [7:0]       seta,
  input  logic [7:0]       setb,
  input  logic [7:0]       mode,
  input  logic [7:0]       wait_ld,
  input  logic [5:0][7:0]  rd_bytes,
  output bus_t             bus_next,
  output logic [4:0]       pos_next,
  output logic [7:0]       delay_next,
  output logic             rd_we,
  output logic [2:0]       rd_sel,
  output logic             pub_ok
);

  entry_t      ent;
  logic [7:0]  wb;
  logic [15:0] wx, wy, wz;

  assign ent = script_entry(pos);
  assign rd_sel = ent.arg;

  // Readings arrive X, Z, Y, each MSB first
  assign wx = {rd_bytes[0], rd_bytes[1]};
  assign wz = {rd_bytes[2], rd_bytes[3]};
  assign wy = {rd_bytes[4], rd_bytes[5]};

  // Byte to send for write entries
  always_comb begin
    unique case (ent.op)
      OP_WADDR:  wb = waddr;
      OP_WRADDR: wb = waddr | 8'h01;
      OP_WA:     wb = seta;
      OP_WB:     wb = setb;
      OP_WMODE:  wb = mode;
      default:   wb = {5'd0, ent.arg};
    endcase
  end

  // Sequencer step
  always_comb begin
    bus_next   = bus;
    pos_next   = pos;
    delay_next = delay;
    rd_we      = 1'b0;
    pub_ok     = 1'b0;
    unique case (ent.op)
      OP_START: begin
        if (bus.phase == PH_IDLE) bus_next.phase = PH_S1;
        else if (bus.phase == PH_READY) pos_next = pos + 5'd1;
      end
      OP_STOP: begin
        if (bus.phase == PH_READY) bus_next.phase = PH_P1;
        else if (bus.phase == PH_IDLE) pos_next = pos + 5'd1;
      end
      OP_READ: begin
        if (bus.phase == PH_READY) begin
          bus_next.rx_byte   = 8'd0;
          bus_next.bit_index = 3'd7;
          bus_next.phase     = PH_R1;
        end else if (bus.phase == PH_RDONE) begin
          rd_we          = 1'b1;
          bus_next.phase = PH_READY;
          pos_next       = pos + 5'd1;
        end
      end
      OP_WAIT: begin
        priority if (delay == 8'd0) delay_next = wait_ld;
        else if (delay == 8'd1) begin
          delay_next = 8'd0;
          pos_next   = pos + 5'd1;
        end else delay_next = delay - 8'd1;
      end
      OP_LOOP: begin
        pub_ok   = (wx != BAD_WORD) && (wy != BAD_WORD) && (wz != BAD_WORD);
        pos_next = 5'd0;
      end
      OP_WADDR, OP_WRADDR, OP_WLIT, OP_WA, OP_WB, OP_WMODE: begin
        if (bus.phase == PH_READY) begin
          bus_next.tx_byte   = wb;
          bus_next.bit_index = 3'd7;
          bus_next.phase     = PH_W1;
        end else if (bus.phase == PH_ACKED || bus.phase == PH_NACKED) begin
          bus_next.phase = PH_READY;
          pos_next       = pos + 5'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/i2c_magnetometer_poller.sv =====
// Top level of the bit-banged bus master that polls a three-axis magnetometer.
//
//  port group   dir  contents
//  s_*          in   one tick word: sampled SCL, SDA
//  m_*          out  one result word per tick: drives, X, Y, Z; tuser = new sample
//  cfg_*        in   register writes: index 0..4, 8-bit data
//
// One tick per clock while s_tready is high: bus phase step and script step are combinational
// between the state registers and the result register.
// s_tready drops only while a result is held and m_tready is low.
// Synchronous reset puts the bus idle with both lines released and script at entry 0.
// cfg_ready is always high; writes to unknown indexes are dropped.
module i2c_magnetometer_poller import imp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] scl_sampled, [1] sda_sampled, [7:2] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [0] scl_drive, [1] sda_drive, [17:2] field_x,
                                 // [33:18] field_y, [49:34] field_z, [55:50] zero
  output logic [0:0]  m_tuser,   // [0] sample_updated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // configuration registers
  logic [7:0] waddr, seta, setb, mode, wait_ld;

  // architectural state
  bus_t            bus;
  logic [4:0]      pos;
  logic [7:0]      delay;
  logic [5:0][7:0] rd_bytes;
  logic [15:0]     px, py, pz;

  // step logic
  bus_t        bus_mid, bus_next;
  logic [4:0]  pos_next;
  logic [7:0]  delay_next;
  logic        rd_we, pub_ok;
  logic [2:0]  rd_sel;
  logic        accept, step;
  logic [15:0] wx, wy, wz;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  // the tick only acts when the slave is not stretching the clock
  assign step      = accept && (s_tdata[0] == bus.scl);

  assign wx = {rd_bytes[0], rd_bytes[1]};
  assign wz = {rd_bytes[2], rd_bytes[3]};
  assign wy = {rd_bytes[4], rd_bytes[5]};

  imp_bus_step u_bus (
    .cur    (bus),
    .sda_in (s_tdata[1]),
    .nxt    (bus_mid)
  );

  imp_script_step u_script (
    .bus        (bus_mid),
    .pos        (pos),
    .delay      (delay),
    .waddr      (waddr),
    .seta       (seta),
    .setb       (setb),
    .mode       (mode),
    .wait_ld    (wait_ld),
    .rd_bytes   (rd_bytes),
    .bus_next   (bus_next),
    .pos_next   (pos_next),
    .delay_next (delay_next),
    .rd_we      (rd_we),
    .rd_sel     (rd_sel),
    .pub_ok     (pub_ok)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      waddr   <= WADDR_RST;
      seta    <= SETA_RST;
      setb    <= SETB_RST;
      mode    <= MODE_RST;
      wait_ld <= WAIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WADDR: waddr   <= cfg_data;
        REG_SETA:  seta    <= cfg_data;
        REG_SETB:  setb    <= cfg_data;
        REG_MODE:  mode    <= cfg_data;
        REG_WAIT:  wait_ld <= cfg_data;
        default: ;
      endcase
    end
  end

  // state update on each non-stretched tick
  always_ff @(posedge clk) begin
    if (rst) begin
      bus.phase     <= PH_IDLE;
      bus.bit_index <= 3'd7;
      bus.tx_byte   <= 8'd0;
      bus.rx_byte   <= 8'd0;
      bus.scl       <= 1'b1;
      bus.sda       <= 1'b1;
      pos           <= 5'd0;
      delay         <= 8'd0;
      rd_bytes      <= '0;
      px            <= 16'd0;
      py            <= 16'd0;
      pz            <= 16'd0;
    end else if (step) begin
      bus   <= bus_next;
      pos   <= pos_next;
      delay <= delay_next;
      if (rd_we) rd_bytes[rd_sel] <= bus_mid.rx_byte;
      if (pub_ok) begin
        px <= wx;
        py <= wy;
        pz <= wz;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (step) begin
        m_tdata <= {6'd0, (pub_ok ? wz : pz), (pub_ok ? wy : py), (pub_ok ? wx : px),
                    bus_next.sda, bus_next.scl};
        m_tuser <= pub_ok;
      end else begin
        m_tdata <= {6'd0, pz, py, px, bus.sda, bus.scl};
        m_tuser <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // a published sample never carries the overflow word
  a_pub_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[17:2] != BAD_WORD) &&
      (m_tdata[33:18] != BAD_WORD) && (m_tdata[49:34] != BAD_WORD))
    else $error("published sample holds overflow word");

  // publishing restarts the script
  a_pub_wrap: assert property (@(posedge clk) disable iff (rst)
    step && pub_ok |=> pos == 5'd0)
    else $error("script did not wrap after publish");

  // a stretched tick leaves the bus machine alone
  a_stretch: assert property (@(posedge clk) disable iff (rst)
    accept && !step |=> $stable(bus.phase) && $stable(bus.scl) && $stable(pos))
    else $error("state changed during clock stretch");

  // every accepted tick leaves a result word
  a_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted tick produced no result");

  // the driven result lines match the bus state after a step
  a_drive: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tdata[0] == bus.scl && m_tdata[1] == bus.sda)
    else $error("result drives differ from bus state");
`endif

endmodule
